FILE: design/chdec_pkg.sv
// Package for the chunked body decoder: shared types, status codes and the hex digit decode.
// It has no dependencies; the parser and the top level import it.
`default_nettype none

package chdec_pkg;

  localparam int unsigned SizeBits  = 64;
  localparam int unsigned LimitBits = 64;

  localparam logic [7:0] ChCr = 8'h0d;
  localparam logic [7:0] ChLf = 8'h0a;

  typedef enum logic [1:0] {
    StBusy  = 2'd0,
    StDone  = 2'd1,
    StFrame = 2'd2,
    StLarge = 2'd3
  } status_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       data_valid;
    status_e    status;
  } result_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] value;
  } hex_t;

  function automatic hex_t hex_decode(input logic [7:0] c);
    hex_t h;
    h.ok    = 1'b1;
    h.value = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.value = 4'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      h.value = 4'(c - 8'h57);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      h.value = 4'(c - 8'h37);
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

endpackage

`default_nettype wire

FILE: design/chdec_parser.sv
// Chunked framing state machine, chunk size counter, body byte budget and limit register.
// Depends on chdec_pkg; the result for the current byte is combinational.
`default_nettype none

module chdec_parser (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_we_i,
  input  wire logic [chdec_pkg::LimitBits-1:0]    cfg_wdata_i,
  input  wire logic                               step_i,
  input  wire logic [7:0]                         byte_i,
  input  wire logic                               start_i,
  output chdec_pkg::result_t                      res_o
);
  import chdec_pkg::*;

  typedef enum logic [3:0] {
    PhSize    = 4'd0,
    PhExt     = 4'd1,
    PhExtLf   = 4'd2,
    PhData    = 4'd3,
    PhEndCr   = 4'd4,
    PhEndLf   = 4'd5,
    PhTrStart = 4'd6,
    PhTrSkip  = 4'd7,
    PhTrLf    = 4'd8,
    PhTrEndLf = 4'd9,
    PhStop    = 4'd10
  } phase_e;

  phase_e                phase_q, phase_d, ph;
  logic                  seen_q, seen_d, seen;
  logic [SizeBits-1:0]   chunk_q, chunk_d, chunk;
  logic [LimitBits-1:0]  used_q, used_d, used;
  logic [LimitBits-1:0]  limit_q;
  status_e               status_q, status_d, st;
  logic                  valid;
  hex_t                  h;

  always_comb begin
    ph    = start_i ? PhSize : phase_q;
    seen  = start_i ? 1'b0 : seen_q;
    chunk = start_i ? '0 : chunk_q;
    used  = start_i ? '0 : used_q;
    st    = start_i ? StBusy : status_q;
    h     = hex_decode(byte_i);

    phase_d  = ph;
    seen_d   = seen;
    chunk_d  = chunk;
    used_d   = used;
    status_d = st;
    valid    = 1'b0;

    unique case (ph)
      PhSize: begin
        if (h.ok) begin
          if (chunk[SizeBits-1 -: 4] != 4'd0) begin
            phase_d  = PhStop;
            status_d = StFrame;
          end else begin
            chunk_d = {chunk[SizeBits-5:0], h.value};
            seen_d  = 1'b1;
          end
        end else if (!seen) begin
          phase_d  = PhStop;
          status_d = StFrame;
        end else begin
          phase_d = (byte_i == ChCr) ? PhExtLf : PhExt;
        end
      end
      PhExt: begin
        if (byte_i == ChCr) begin
          phase_d = PhExtLf;
        end
      end
      PhExtLf: begin
        if (byte_i != ChLf) begin
          phase_d  = PhStop;
          status_d = StFrame;
        end else begin
          phase_d = (chunk == '0) ? PhTrStart : PhData;
        end
      end
      PhData: begin
        if (used == limit_q) begin
          phase_d  = PhStop;
          status_d = StLarge;
        end else begin
          used_d  = used + LimitBits'(1);
          chunk_d = chunk - SizeBits'(1);
          valid   = 1'b1;
          if (chunk == SizeBits'(1)) begin
            phase_d = PhEndCr;
          end
        end
      end
      PhEndCr: begin
        if (byte_i != ChCr) begin
          phase_d  = PhStop;
          status_d = StFrame;
        end else begin
          phase_d = PhEndLf;
        end
      end
      PhEndLf: begin
        if (byte_i != ChLf) begin
          phase_d  = PhStop;
          status_d = StFrame;
        end else begin
          phase_d = PhSize;
          seen_d  = 1'b0;
          chunk_d = '0;
        end
      end
      PhTrStart: begin
        phase_d = (byte_i == ChCr) ? PhTrEndLf : PhTrSkip;
      end
      PhTrSkip: begin
        if (byte_i == ChCr) begin
          phase_d = PhTrLf;
        end
      end
      PhTrLf: begin
        if (byte_i != ChLf) begin
          phase_d  = PhStop;
          status_d = StFrame;
        end else begin
          phase_d = PhTrStart;
        end
      end
      PhTrEndLf: begin
        phase_d  = PhStop;
        status_d = (byte_i != ChLf) ? StFrame : StDone;
      end
      PhStop: begin
      end
      default: begin
        phase_d  = PhStop;
        status_d = StFrame;
      end
    endcase

    res_o.data_byte  = valid ? byte_i : 8'd0;
    res_o.data_valid = valid;
    res_o.status     = status_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhSize;
      seen_q   <= 1'b0;
      chunk_q  <= '0;
      used_q   <= '0;
      limit_q  <= '1;
      status_q <= StBusy;
    end else begin
      if (step_i) begin
        phase_q  <= phase_d;
        seen_q   <= seen_d;
        chunk_q  <= chunk_d;
        used_q   <= used_d;
        status_q <= status_d;
      end else if (cfg_we_i) begin
        // A smaller limit clamps the count of bytes already passed.
        used_q <= (cfg_wdata_i > used_q) ? used_q : cfg_wdata_i;
      end
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
    end
  end

endmodule

`default_nettype wire

FILE: design/http_chunked_body_decoder.sv
// A result passes through the input register, then the result register, before it is offered.
// Throughput: one byte per cycle while the result side takes results; the parser state updates as each
// byte moves to the result register. While a finished result waits to be taken, the input register
// can still take one byte; then the input side stalls.
// Reset (rst_ni low, asynchronous) empties both registers, sets the limit to all ones and
// puts the parser at the start of a body.
// Top level of the chunked body decoder; depends on chdec_pkg and chdec_parser.
`default_nettype none

module http_chunked_body_decoder (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [chdec_pkg::LimitBits-1:0] cfg_wdata_i,
  input  wire logic                            s_axis_tvalid_i,
  output      logic                            s_axis_tready_o,
  input  wire logic [7:0]                      s_axis_tdata_i,  // [7:0] in_byte
  input  wire logic                            s_axis_tuser_i,  // [0] body_start
  output      logic                            m_axis_tvalid_o,
  input  wire logic                            m_axis_tready_i,
  output      logic [7:0]                      m_axis_tdata_o,  // [7:0] data_byte
  output      logic [2:0]                      m_axis_tuser_o   // [0] data_valid, [2:1] status
);
  import chdec_pkg::*;

  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_start_q;
  logic       out_valid_q;
  result_t    out_q;
  result_t    res;
  logic       advance;

  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;

  chdec_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .step_i      (advance),
    .byte_i      (in_byte_q),
    .start_i     (in_start_q),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready_o) begin
        in_valid_q <= s_axis_tvalid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_byte_q  <= s_axis_tdata_i;
      in_start_q <= s_axis_tuser_i;
    end
    if (advance) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_q.data_byte;
  assign m_axis_tuser_o  = {out_q.status, out_q.data_valid};

endmodule

`default_nettype wire

FILE: sim/tb_http_chunked_body_decoder.sv
// Self-checking testbench for http_chunked_body_decoder: directed and random chunked bodies,
// random idling on both streams and body limit rewrites, checked against a local decoder model.
// Depends on chdec_pkg and the RTL of the decoder.
`timescale 1ns / 1ps

typedef enum logic [3:0] {
  PhSize,
  PhExt,
  PhExtLf,
  PhData,
  PhEndCr,
  PhEndLf,
  PhTrStart,
  PhTrSkip,
  PhTrLf,
  PhTrEndLf,
  PhStop
} chunk_phase_e;

class chunk_scoreboard;
  logic [63:0]        limit;
  logic [63:0]        budget;
  logic [63:0]        chunk_left;
  logic               digit_seen;
  chunk_phase_e       phase;
  chdec_pkg::status_e sticky;
  chdec_pkg::result_t expected_q[$];
  int                 errors;

  function new();
    limit  = '1;
    errors = 0;
    restart();
  endfunction

  function void restart();
    phase      = PhSize;
    digit_seen = 1'b0;
    chunk_left = '0;
    budget     = limit;
    sticky     = chdec_pkg::StBusy;
  endfunction

  function void halt(chdec_pkg::status_e code);
    phase  = PhStop;
    sticky = code;
  endfunction

  // Bytes already passed in the current body stay counted against the new limit.
  function void write_limit(logic [63:0] value);
    logic [63:0] used;
    used   = limit - budget;
    budget = (value > used) ? value - used : '0;
    limit  = value;
  endfunction

  function void note_input(logic [7:0] c, logic start);
    logic [63:0]        size_max;
    logic [3:0]         nib;
    logic               is_hex;
    chdec_pkg::result_t r;
    size_max     = {64{1'b1}} >> (64 - chdec_pkg::SizeBits);
    is_hex       = 1'b1;
    nib          = '0;
    r.data_byte  = '0;
    r.data_valid = 1'b0;
    if (c >= 8'h30 && c <= 8'h39) begin
      nib = 4'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      nib = 4'(c - 8'h57);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      nib = 4'(c - 8'h37);
    end else begin
      is_hex = 1'b0;
    end
    if (start) restart();
    case (phase)
      PhSize: begin
        if (is_hex) begin
          if (chunk_left > (size_max >> 4)) begin
            halt(chdec_pkg::StFrame);
          end else begin
            chunk_left = ((chunk_left << 4) | 64'(nib)) & size_max;
            digit_seen = 1'b1;
          end
        end else if (!digit_seen) begin
          halt(chdec_pkg::StFrame);
        end else begin
          phase = (c == chdec_pkg::ChCr) ? PhExtLf : PhExt;
        end
      end
      PhExt: begin
        if (c == chdec_pkg::ChCr) phase = PhExtLf;
      end
      PhExtLf: begin
        if (c != chdec_pkg::ChLf) halt(chdec_pkg::StFrame);
        else phase = (chunk_left == 0) ? PhTrStart : PhData;
      end
      PhData: begin
        if (budget == 0) begin
          halt(chdec_pkg::StLarge);
        end else begin
          budget       = budget - 1;
          chunk_left   = chunk_left - 1;
          r.data_valid = 1'b1;
          r.data_byte  = c;
          if (chunk_left == 0) phase = PhEndCr;
        end
      end
      PhEndCr: begin
        if (c != chdec_pkg::ChCr) halt(chdec_pkg::StFrame);
        else phase = PhEndLf;
      end
      PhEndLf: begin
        if (c != chdec_pkg::ChLf) begin
          halt(chdec_pkg::StFrame);
        end else begin
          phase      = PhSize;
          digit_seen = 1'b0;
          chunk_left = '0;
        end
      end
      PhTrStart: begin
        phase = (c == chdec_pkg::ChCr) ? PhTrEndLf : PhTrSkip;
      end
      PhTrSkip: begin
        if (c == chdec_pkg::ChCr) phase = PhTrLf;
      end
      PhTrLf: begin
        if (c != chdec_pkg::ChLf) halt(chdec_pkg::StFrame);
        else phase = PhTrStart;
      end
      PhTrEndLf: begin
        if (c != chdec_pkg::ChLf) halt(chdec_pkg::StFrame);
        else halt(chdec_pkg::StDone);
      end
      PhStop: begin
      end
      default: begin
        halt(chdec_pkg::StFrame);
      end
    endcase
    r.status = sticky;
    expected_q.push_back(r);
  endfunction

  function void check_result(logic [7:0] tdata, logic [2:0] tuser);
    chdec_pkg::result_t e;
    if (expected_q.size() == 0) begin
      $error("result transfer with nothing expected: data_byte %0h, tuser %0h", tdata, tuser);
      errors++;
      return;
    end
    e = expected_q.pop_front();
    if (tdata !== e.data_byte) begin
      $error("data_byte: expected %0h, actual %0h", e.data_byte, tdata);
      errors++;
    end
    if (tuser[0] !== e.data_valid) begin
      $error("data_valid: expected %0d, actual %0d", e.data_valid, tuser[0]);
      errors++;
    end
    if (tuser[2:1] !== e.status) begin
      $error("status: expected %0d, actual %0d", e.status, tuser[2:1]);
      errors++;
    end
  endfunction

  function int pending();
    return expected_q.size();
  endfunction
endclass

module tb_http_chunked_body_decoder;
  import chdec_pkg::*;

  localparam int unsigned CycleLimit = 200000;

  logic                 clk_i           = 1'b0;
  logic                 rst_ni          = 1'b0;
  logic                 cfg_we_i        = 1'b0;
  logic [LimitBits-1:0] cfg_wdata_i     = '0;
  logic                 s_axis_tvalid_i = 1'b0;
  logic                 s_axis_tready_o;
  logic [7:0]           s_axis_tdata_i  = '0;
  logic                 s_axis_tuser_i  = 1'b0;
  logic                 m_axis_tvalid_o;
  logic                 m_axis_tready_i = 1'b0;
  logic [7:0]           m_axis_tdata_o;
  logic [2:0]           m_axis_tuser_o;

  chunk_scoreboard sb;
  logic [7:0]      msg_q[$];
  int              idle_pct    = 10;
  int unsigned     cycle_count = 0;

  http_chunked_body_decoder DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    m_axis_tready_i <= ($urandom_range(99) >= idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      sb.check_result(m_axis_tdata_o, m_axis_tuser_o);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic start);
    if ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= b;
    s_axis_tuser_i  <= start;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    sb.note_input(b, start);
  endtask

  task automatic wait_idle();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic set_limit(input logic [63:0] value);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    sb.write_limit(value);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [63:0] pick_limit();
    case ($urandom_range(4))
      0:       return '0;
      1:       return '1;
      2:       return 64'($urandom_range(1, 40));
      3:       return {$urandom, $urandom};
      default: return 64'($urandom_range(5, 25));
    endcase
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 10) return 8'h30 + 8'(n);
    return ($urandom_range(1) ? 8'h61 : 8'h41) + 8'(n) - 8'd10;
  endfunction

  function automatic logic [7:0] text_byte();
    logic [7:0] b;
    b = 8'($urandom);
    while (b == ChCr) b = 8'($urandom);
    return b;
  endfunction

  task automatic push_crlf();
    msg_q.push_back(ChCr);
    msg_q.push_back(ChLf);
  endtask

  task automatic push_size_line(input logic [63:0] size);
    logic [7:0] digits[$];
    logic [63:0] v;
    v = size;
    repeat ($urandom_range(0, 2)) msg_q.push_back(8'h30);
    do begin
      digits.push_front(hex_char(v[3:0]));
      v = v >> 4;
    end while (v != 0);
    foreach (digits[i]) msg_q.push_back(digits[i]);
    if ($urandom_range(3) == 0) begin
      msg_q.push_back(8'h3b);
      repeat ($urandom_range(0, 4)) msg_q.push_back(text_byte());
    end
    push_crlf();
  endtask

  task automatic build_body();
    int size;
    msg_q.delete();
    repeat ($urandom_range(0, 3)) begin
      size = ($urandom_range(9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
      push_size_line(64'(size));
      repeat (size) msg_q.push_back(8'($urandom));
      push_crlf();
    end
    push_size_line(64'd0);
    repeat ($urandom_range(0, 2)) begin
      repeat ($urandom_range(1, 5)) msg_q.push_back(text_byte());
      push_crlf();
    end
    push_crlf();
  endtask

  // Sizes at and just past the width of the chunk counter.
  task automatic build_huge();
    msg_q.delete();
    msg_q.push_back(hex_char(4'($urandom_range(1, 15))));
    repeat ($urandom_range(15, 16)) msg_q.push_back(hex_char(4'($urandom)));
    push_crlf();
    repeat ($urandom_range(0, 3)) msg_q.push_back(8'($urandom));
  endtask

  task automatic send_msg(input logic start_first, input int rewrite_at);
    logic start;
    foreach (msg_q[i]) begin
      if (i == rewrite_at) set_limit(pick_limit());
      start = (i == 0) ? start_first : ($urandom_range(199) == 0);
      send_byte(msg_q[i], start);
    end
  endtask

  initial begin
    int rand_items;
    int next_cfg;
    int kind;
    int rewrite_at;
    int keep;
    sb = new();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Budget spent: a zero limit refuses the first payload byte.
    set_limit('0);
    msg_q = '{8'h31, ChCr, ChLf, 8'hff};
    send_msg(1'b1, -1);
    set_limit('1);
    // Empty size, then a byte that is ignored after the error.
    send_byte(8'h47, 1'b1);
    send_byte(8'h00, 1'b0);
    // Smallest complete body: zero chunk and an empty trailer.
    msg_q = '{8'h30, ChCr, ChLf, ChCr, ChLf};
    send_msg(1'b1, -1);
    // Sixteen digits fill the counter, the seventeenth overflows it.
    msg_q.delete();
    repeat (17) msg_q.push_back(8'h46);
    send_msg(1'b1, -1);
    // Stray CR after the size.
    msg_q = '{8'h31, ChCr, 8'h78};
    send_msg(1'b1, -1);

    rand_items = 0;
    next_cfg   = 40;
    while (rand_items < 650) begin
      idle_pct = (rand_items >= 250 && rand_items < 400) ? 0 : 10;
      if (rand_items >= next_cfg) begin
        set_limit(pick_limit());
        next_cfg += $urandom_range(60, 120);
      end
      kind       = $urandom_range(99);
      rewrite_at = -1;
      if (kind < 78) begin
        if (kind < 70) build_body();
        else build_huge();
        if (kind < 70 && $urandom_range(99) < 15) begin
          msg_q[$urandom_range(msg_q.size() - 1)] = 8'($urandom);
        end
        if ($urandom_range(99) < 10) begin
          keep = $urandom_range(1, msg_q.size());
          while (msg_q.size() > keep) void'(msg_q.pop_back());
        end
        if (msg_q.size() > 1 && $urandom_range(99) < 5) begin
          rewrite_at = $urandom_range(1, msg_q.size() - 1);
        end
        send_msg(1'b1, rewrite_at);
        rand_items += msg_q.size();
      end else if (kind < 88) begin
        msg_q.delete();
        repeat ($urandom_range(1, 6)) msg_q.push_back(8'($urandom));
        send_msg(1'b1, -1);
        rand_items += msg_q.size();
      end else if (kind < 94) begin
        msg_q.delete();
        repeat ($urandom_range(1, 3)) msg_q.push_back(8'($urandom));
        send_msg(1'b0, -1);
      end else begin
        build_body();
        send_msg(1'b0, -1);
        rand_items += msg_q.size();
      end
    end

    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

FILE: http_chunked_body_decoder.f
design/chdec_pkg.sv
design/chdec_parser.sv
design/http_chunked_body_decoder.sv
sim/tb_http_chunked_body_decoder.sv
